@@ design/cfr_pkg.sv @@
// Shared types, constants and helpers for the chunked frame receiver.
// No dependencies; imported by every module of the block.
package cfr_pkg;

   localparam int TOTAL_BITS_DEF = 16;
   localparam int TIMER_BITS_DEF = 32;

   localparam int MAX_RESULTS = 5;
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

   localparam logic [1:0] REQ_BYTE  = 2'd0;
   localparam logic [1:0] REQ_TICK  = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;

   localparam logic [2:0] KIND_PAYLOAD  = 3'd0;
   localparam logic [2:0] KIND_TX       = 3'd1;
   localparam logic [2:0] KIND_DONE     = 3'd2;
   localparam logic [2:0] KIND_OVERFLOW = 3'd3;
   localparam logic [2:0] KIND_TIMEOUT  = 3'd4;

   localparam logic [1:0] CSR_MAX_PAYLOAD    = 2'd0;
   localparam logic [1:0] CSR_BUFFER_SIZE    = 2'd1;
   localparam logic [1:0] CSR_TIMEOUT_TICKS  = 2'd2;
   localparam logic [1:0] CSR_TIMEOUT_ENABLE = 2'd3;

   localparam logic [7:0]  MAX_PAYLOAD_RST    = 8'd8;
   localparam logic [15:0] BUFFER_SIZE_RST    = 16'd4096;
   localparam logic [31:0] TIMEOUT_TICKS_RST  = 32'd100;
   localparam logic        TIMEOUT_ENABLE_RST = 1'b1;

   localparam logic [7:0] CHAR_CR   = 8'h0D;
   localparam logic [7:0] CHAR_O    = 8'h4F;
   localparam logic [7:0] CHAR_K    = 8'h4B;
   localparam logic [7:0] CHAR_ZERO = 8'h30;

   typedef struct packed {
      logic [7:0]  max_payload;
      logic [15:0] buffer_size;
      logic [31:0] timeout_ticks;
      logic        timeout_enable;
   } cfg_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] data;
   } entry_type;

   typedef struct packed {
      logic [CNT_W-1:0]                  count;
      logic                              dead;
      logic [7:0]                        cmd;
      entry_type [MAX_RESULTS-1:0]       entries;
   } bundle_type;

   typedef struct packed {
      logic load;
      logic halted;
   } parser_status_type;

   // {valid, value}
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
      else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
      else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
      return r;
   endfunction

endpackage

@@ design/cfr_parser.sv @@
// Input register, header/payload parser state and per-request result bundle.
// Depends on cfr_pkg.
module cfr_parser
   import cfr_pkg::*;
#(
   parameter int TOTAL_BITS = TOTAL_BITS_DEF,
   parameter int TIMER_BITS = TIMER_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_req_type,
   input  logic [7:0]            req_rx_byte,
   input  cfg_type               cfg,
   input  logic                  bundle_ready,
   output bundle_type            bundle,
   output logic [TOTAL_BITS-1:0] bundle_total,
   output parser_status_type     status
);

   localparam int SUM_W = ((TOTAL_BITS > 16) ? TOTAL_BITS : 16) + 1;

   typedef enum logic {PH_HEADER, PH_PAYLOAD} phase_type;

   logic                  in_valid_ff, in_valid_in;
   logic [1:0]            in_type_ff;
   logic [7:0]            in_byte_ff;

   phase_type             phase_ff, phase_in;
   logic [1:0]            hc_ff, hc_in;
   logic [7:0]            cmd_ff, cmd_in;
   logic [3:0]            high_ff, high_in;
   logic                  dv_ff, dv_in;
   logic [7:0]            rem_ff, rem_in;
   logic [TOTAL_BITS-1:0] total_ff, total_in;
   logic                  more_ff, more_in;
   logic                  msg_ff, msg_in;
   logic [TIMER_BITS-1:0] tick_ff, tick_in;
   logic                  dead_ff, dead_in;
   logic                  halted_ff, halted_in;

   logic                  advance;
   logic                  fin;
   logic [4:0]            h;
   logic [7:0]            len;
   logic [TOTAL_BITS-1:0] done_total;
   logic [CNT_W-1:0]      n;
   entry_type [MAX_RESULTS-1:0] ent;

   assign advance     = in_valid_ff && bundle_ready;
   assign req_stall   = in_valid_ff && !bundle_ready;
   assign in_valid_in = req_valid || (in_valid_ff && !advance);

   always_comb begin
      phase_in   = phase_ff;
      hc_in      = hc_ff;
      cmd_in     = cmd_ff;
      high_in    = high_ff;
      dv_in      = dv_ff;
      rem_in     = rem_ff;
      total_in   = total_ff;
      more_in    = more_ff;
      msg_in     = msg_ff;
      tick_in    = tick_ff;
      dead_in    = dead_ff;
      halted_in  = halted_ff;
      fin        = 1'b0;
      len        = 8'd0;
      done_total = '0;
      n          = '0;
      ent        = '0;
      h          = hex_decode(in_byte_ff);
      if (advance && !halted_ff) begin
         case (in_type_ff)
            REQ_BYTE: begin
               if (phase_ff == PH_PAYLOAD) begin
                  ent[n]   = '{kind: KIND_PAYLOAD, data: in_byte_ff};
                  n        = n + 1'b1;
                  total_in = total_ff + 1'b1;
                  rem_in   = rem_ff - 8'd1;
                  if (rem_in == 8'd0) fin = 1'b1;
               end else begin
                  case (hc_ff)
                     2'd0: begin
                        cmd_in = in_byte_ff;
                        if (!msg_ff) begin
                           msg_in   = 1'b1;
                           tick_in  = '0;
                           total_in = '0;
                        end
                        hc_in = 2'd1;
                     end
                     2'd1: begin
                        dv_in   = h[4];
                        high_in = h[3:0];
                        hc_in   = 2'd2;
                     end
                     default: begin
                        hc_in   = 2'd0;
                        tick_in = '0;
                        if (cmd_ff == CHAR_CR) begin
                           ent[n] = '{kind: KIND_TX, data: CHAR_O};
                           n      = n + 1'b1;
                           ent[n] = '{kind: KIND_TX, data: CHAR_K};
                           n      = n + 1'b1;
                           msg_in = more_ff;
                        end else begin
                           if (!dv_ff) len = 8'd0;
                           else if (!h[4]) len = {4'd0, high_ff};
                           else len = {high_ff, h[3:0]};
                           if (len > cfg.max_payload) begin
                              len     = cfg.max_payload;
                              more_in = 1'b1;
                           end else begin
                              more_in = 1'b0;
                           end
                           if (SUM_W'(len) + SUM_W'(total_ff) > SUM_W'(cfg.buffer_size)) begin
                              ent[n]    = '{kind: KIND_OVERFLOW, data: 8'd0};
                              n         = n + 1'b1;
                              phase_in  = PH_HEADER;
                              hc_in     = 2'd0;
                              high_in   = 4'd0;
                              dv_in     = 1'b0;
                              rem_in    = 8'd0;
                              total_in  = '0;
                              more_in   = 1'b0;
                              msg_in    = 1'b0;
                              tick_in   = '0;
                              halted_in = 1'b1;
                           end else if (len == 8'd0) begin
                              fin = 1'b1;
                           end else begin
                              rem_in   = len;
                              phase_in = PH_PAYLOAD;
                           end
                        end
                     end
                  endcase
               end
            end
            REQ_TICK: begin
               if (msg_ff && cfg.timeout_enable) begin
                  if (tick_ff != '1) tick_in = tick_ff + 1'b1;
                  if (32'(tick_in) > cfg.timeout_ticks) begin
                     dead_in  = 1'b1;
                     phase_in = PH_HEADER;
                     hc_in    = 2'd0;
                     high_in  = 4'd0;
                     dv_in    = 1'b0;
                     rem_in   = 8'd0;
                     total_in = '0;
                     more_in  = 1'b0;
                     msg_in   = 1'b0;
                     tick_in  = '0;
                     ent[n]   = '{kind: KIND_TIMEOUT, data: 8'd0};
                     n        = n + 1'b1;
                  end
               end
            end
            REQ_CLEAR: begin
               dead_in  = 1'b0;
               phase_in = PH_HEADER;
               hc_in    = 2'd0;
               high_in  = 4'd0;
               dv_in    = 1'b0;
               rem_in   = 8'd0;
               total_in = '0;
               more_in  = 1'b0;
               msg_in   = 1'b0;
               tick_in  = '0;
            end
            default: begin
            end
         endcase
         if (fin) begin
            ent[n]   = '{kind: KIND_TX, data: cmd_in};
            n        = n + 1'b1;
            ent[n]   = '{kind: KIND_TX, data: CHAR_ZERO};
            n        = n + 1'b1;
            ent[n]   = '{kind: KIND_TX, data: CHAR_ZERO};
            n        = n + 1'b1;
            phase_in = PH_HEADER;
            tick_in  = '0;
            if (!more_in) begin
               ent[n]     = '{kind: KIND_DONE, data: 8'd0};
               n          = n + 1'b1;
               done_total = total_in;
               total_in   = '0;
               msg_in     = 1'b0;
            end
         end
      end
   end

   assign bundle.count   = n;
   assign bundle.dead    = dead_in;
   assign bundle.cmd     = cmd_in;
   assign bundle.entries = ent;
   assign bundle_total   = done_total;
   assign status.load    = advance;
   assign status.halted  = halted_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         phase_ff    <= PH_HEADER;
         hc_ff       <= 2'd0;
         cmd_ff      <= 8'd0;
         high_ff     <= 4'd0;
         dv_ff       <= 1'b0;
         rem_ff      <= 8'd0;
         total_ff    <= '0;
         more_ff     <= 1'b0;
         msg_ff      <= 1'b0;
         tick_ff     <= '0;
         dead_ff     <= 1'b0;
         halted_ff   <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         phase_ff    <= phase_in;
         hc_ff       <= hc_in;
         cmd_ff      <= cmd_in;
         high_ff     <= high_in;
         dv_ff       <= dv_in;
         rem_ff      <= rem_in;
         total_ff    <= total_in;
         more_ff     <= more_in;
         msg_ff      <= msg_in;
         tick_ff     <= tick_in;
         dead_ff     <= dead_in;
         halted_ff   <= halted_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!in_valid_ff || advance) begin
         in_type_ff <= req_req_type;
         in_byte_ff <= req_rx_byte;
      end
   end

endmodule

@@ design/cfr_result_queue.sv @@
// Result bundle register: holds up to five results of one request and sends
// them one per cycle while rsp_stall is low. Depends on cfr_pkg.
module cfr_result_queue
   import cfr_pkg::*;
#(
   parameter int TOTAL_BITS = TOTAL_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  bundle_type            bundle,
   input  logic [TOTAL_BITS-1:0] bundle_total,
   output logic                  bundle_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [2:0]            rsp_out_kind,
   output logic [7:0]            rsp_out_byte,
   output logic [7:0]            rsp_msg_cmd,
   output logic [TOTAL_BITS-1:0] rsp_msg_total,
   output logic                  rsp_last_of_run,
   output logic                  rsp_dead_flag
);

   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [CNT_W-1:0]            idx_ff, idx_in;
   entry_type [MAX_RESULTS-1:0] ent_ff;
   logic                        dead_ff;
   logic [7:0]                  cmd_ff;
   logic [TOTAL_BITS-1:0]       total_ff;
   logic                        take;
   logic                        last;
   logic                        is_done;
   entry_type                   cur;

   assign rsp_valid    = (cnt_ff != '0);
   assign last         = (idx_ff == cnt_ff - 1'b1);
   assign take         = rsp_valid && !rsp_stall;
   assign bundle_ready = !rsp_valid || (take && last);
   assign cur          = ent_ff[idx_ff];
   assign is_done      = (cur.kind == KIND_DONE);

   assign rsp_out_kind    = cur.kind;
   assign rsp_out_byte    = cur.data;
   assign rsp_msg_cmd     = is_done ? cmd_ff : 8'd0;
   assign rsp_msg_total   = is_done ? total_ff : '0;
   assign rsp_last_of_run = last;
   assign rsp_dead_flag   = dead_ff;

   always_comb begin
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      if (load) begin
         cnt_in = bundle.count;
         idx_in = '0;
      end else if (take) begin
         if (last) cnt_in = '0;
         else idx_in = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         idx_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         ent_ff   <= bundle.entries;
         dead_ff  <= bundle.dead;
         cmd_ff   <= bundle.cmd;
         total_ff <= bundle_total;
      end
   end

endmodule

@@ design/chunked_frame_receiver_core.sv @@
// Chunked frame receiver top level: configuration registers, parser, result queue.
// Depends on cfr_pkg, cfr_parser and cfr_result_queue.
// Path: a request passes the input register, then the result queue register; a busy queue holds it in the first.
// Throughput: one request per cycle while each gives at most one result and rsp_stall is low;
//   a request giving several results holds the next one until its last result leaves (one per cycle unless stalled).
// Reset: synchronous, active high; clears parser state, queue and registers.
module chunked_frame_receiver_core
   import cfr_pkg::*;
#(
   parameter int TOTAL_BITS = TOTAL_BITS_DEF,
   parameter int TIMER_BITS = TIMER_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_req_type,
   input  logic [7:0]            req_rx_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [2:0]            rsp_out_kind,
   output logic [7:0]            rsp_out_byte,
   output logic [7:0]            rsp_msg_cmd,
   output logic [TOTAL_BITS-1:0] rsp_msg_total,
   output logic                  rsp_last_of_run,
   output logic                  rsp_dead_flag,
   input  logic                  csr_wr_en,
   input  logic [1:0]            csr_index,
   input  logic [31:0]           csr_wdata
);

   cfg_type               cfg_ff;
   bundle_type            bundle;
   logic [TOTAL_BITS-1:0] bundle_total;
   logic                  bundle_ready;
   parser_status_type     status;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_payload    <= MAX_PAYLOAD_RST;
         cfg_ff.buffer_size    <= BUFFER_SIZE_RST;
         cfg_ff.timeout_ticks  <= TIMEOUT_TICKS_RST;
         cfg_ff.timeout_enable <= TIMEOUT_ENABLE_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_MAX_PAYLOAD:    cfg_ff.max_payload    <= csr_wdata[7:0];
            CSR_BUFFER_SIZE:    cfg_ff.buffer_size    <= csr_wdata[15:0];
            CSR_TIMEOUT_TICKS:  cfg_ff.timeout_ticks  <= csr_wdata;
            CSR_TIMEOUT_ENABLE: cfg_ff.timeout_enable <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   cfr_parser #(
      .TOTAL_BITS(TOTAL_BITS),
      .TIMER_BITS(TIMER_BITS)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_req_type (req_req_type),
      .req_rx_byte  (req_rx_byte),
      .cfg          (cfg_ff),
      .bundle_ready (bundle_ready),
      .bundle       (bundle),
      .bundle_total (bundle_total),
      .status       (status)
   );

   cfr_result_queue #(
      .TOTAL_BITS(TOTAL_BITS)
   ) u_queue (
      .clock           (clock),
      .reset           (reset),
      .load            (status.load),
      .bundle          (bundle),
      .bundle_total    (bundle_total),
      .bundle_ready    (bundle_ready),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_kind    (rsp_out_kind),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_msg_cmd     (rsp_msg_cmd),
      .rsp_msg_total   (rsp_msg_total),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_dead_flag   (rsp_dead_flag)
   );

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      status.halted |=> status.halted)
      else $error("halt released without reset");

   a_halt_silent: assert property (@(posedge clock) disable iff (reset)
      (status.load && status.halted) |-> (bundle.count == '0))
      else $error("result produced while halted");

   a_timeout_dead: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_kind == KIND_TIMEOUT) |-> rsp_dead_flag)
      else $error("timeout result without dead flag");

   a_total_only_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_kind != KIND_DONE) |-> (rsp_msg_total == '0 && rsp_msg_cmd == 8'd0))
      else $error("message fields set on non-done result");

endmodule

@@ tb/chunked_frame_receiver_core_test.sv @@
// Self-checking testbench for chunked_frame_receiver_core: directed table, then random
// framed traffic over several register settings, checked against an in-bench predictor.
// Depends on cfr_pkg and the chunked_frame_receiver_core RTL only.
module chunked_frame_receiver_core_test
   import cfr_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] REQ_SPARE = 2'd3;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int LONG_HOLD = 300;
   localparam int DRAIN_CYCLES = 8;
   localparam int PHASE_ITEMS = 50;
   localparam int DIR_ROWS = 24;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  data;
      logic [7:0]  cmd;
      logic [15:0] total;
      logic        last;
      logic        dead;
   } frame_result_type;

   typedef struct packed {
      logic [1:0] rtype;
      logic [7:0] rbyte;
   } link_req_type;

   typedef struct packed {
      logic [1:0] rtype;
      logic [7:0] rbyte;
      logic       chk;
      logic [2:0] ekind;
      logic [7:0] ebyte;
   } dir_row_type;

   localparam logic [7:0] NON_HEX [8] = '{8'h20, 8'h2D, 8'h2B, 8'h67,
                                          8'h5A, 8'h00, 8'hFF, 8'h3A};

   // chk rows carry the first result of the request, typed in by hand
   localparam dir_row_type DIRECTED [DIR_ROWS] = '{
      '{REQ_TICK,  8'h00, 1'b0, KIND_PAYLOAD, 8'h00},
      '{REQ_SPARE, 8'hFF, 1'b0, KIND_PAYLOAD, 8'h00},
      '{REQ_BYTE,  "A",   1'b0, KIND_PAYLOAD, 8'h00},
      '{REQ_BYTE,  "0",   1'b0, KIND_PAYLOAD, 8'h00},
      '{REQ_BYTE,  "2",   1'b0, KIND_PAYLOAD, 8'h00},
      '{REQ_BYTE,  8'h00, 1'b1, KIND_PAYLOAD, 8'h00},
      '{REQ_BYTE,  8'hFF, 1'b1, KIND_PAYLOAD, 8'hFF},
      '{REQ_BYTE,  CHAR_CR, 1'b0, KIND_PAYLOAD, 8'h00},
      '{REQ_BYTE,  "x",   1'b0, KIND_PAYLOAD, 8'h00},
      '{REQ_BYTE,  "y",   1'b1, KIND_TX,      CHAR_O},
      '{REQ_BYTE,  "Z",   1'b0, KIND_PAYLOAD, 8'h00},
      '{REQ_BYTE,  " ",   1'b0, KIND_PAYLOAD, 8'h00},
      '{REQ_BYTE,  "5",   1'b1, KIND_TX,      "Z"},
      '{REQ_BYTE,  "q",   1'b0, KIND_PAYLOAD, 8'h00},
      '{REQ_BYTE,  "1",   1'b0, KIND_PAYLOAD, 8'h00},
      '{REQ_BYTE,  "-",   1'b0, KIND_PAYLOAD, 8'h00},
      '{REQ_BYTE,  8'h80, 1'b1, KIND_PAYLOAD, 8'h80},
      '{REQ_BYTE,  "C",   1'b0, KIND_PAYLOAD, 8'h00},
      '{REQ_BYTE,  "a",   1'b0, KIND_PAYLOAD, 8'h00},
      '{REQ_CLEAR, 8'h00, 1'b0, KIND_PAYLOAD, 8'h00},
      '{REQ_BYTE,  "E",   1'b0, KIND_PAYLOAD, 8'h00},
      '{REQ_BYTE,  "F",   1'b0, KIND_PAYLOAD, 8'h00},
      '{REQ_BYTE,  "F",   1'b0, KIND_PAYLOAD, 8'h00},
      '{REQ_CLEAR, 8'h5A, 1'b0, KIND_PAYLOAD, 8'h00}
   };

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_req_type = REQ_TICK;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_out_kind;
   logic [7:0]  rsp_out_byte;
   logic [7:0]  rsp_msg_cmd;
   logic [15:0] rsp_msg_total;
   logic        rsp_last_of_run;
   logic        rsp_dead_flag;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_index = CSR_MAX_PAYLOAD;
   logic [31:0] csr_wdata = 32'd0;

   chunked_frame_receiver_core i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_req_type(req_req_type), .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_out_kind(rsp_out_kind), .rsp_out_byte(rsp_out_byte),
      .rsp_msg_cmd(rsp_msg_cmd), .rsp_msg_total(rsp_msg_total),
      .rsp_last_of_run(rsp_last_of_run), .rsp_dead_flag(rsp_dead_flag),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------- receiver mirror ----------------
   logic [7:0]  set_max_payload = MAX_PAYLOAD_RST;
   logic [15:0] set_buffer_size = BUFFER_SIZE_RST;
   logic [31:0] set_timeout = TIMEOUT_TICKS_RST;
   logic        set_timeout_en = TIMEOUT_ENABLE_RST;

   logic        in_payload = 1'b0;
   logic [1:0]  hdr_pos = '0;
   logic [7:0]  cmd_char = '0;
   logic [7:0]  hi_nibble = '0;
   logic        hi_ok = 1'b0;
   logic [7:0]  chunk_left = '0;
   logic [15:0] msg_bytes = '0;
   logic        more_chunks = 1'b0;
   logic        msg_open = 1'b0;
   logic [31:0] tick_cnt = '0;
   logic        dead_seen = 1'b0;
   logic        stopped = 1'b0;

   frame_result_type expected_results[$];
   link_req_type     stim_q[$];

   int mismatch_count = 0;
   int result_count = 0;
   int req_count = 0;
   int idle_cycles = 0;
   int kind_seen[5] = '{default: 0};
   int sender_burst = 0;
   bit hold_off_req = 1'b0;

   function automatic int nibble_value(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - 8'h30);
      if (c >= "a" && c <= "f") return int'(c - 8'h57);
      if (c >= "A" && c <= "F") return int'(c - 8'h37);
      return -1;
   endfunction

   function automatic void add_result(input logic [2:0] kind, input logic [7:0] data,
                                      input logic [7:0] cmd, input logic [15:0] total);
      expected_results.push_back('{kind, data, cmd, total, 1'b0, 1'b0});
   endfunction

   function automatic void drop_message();
      in_payload = 1'b0;
      hdr_pos = '0;
      hi_nibble = '0;
      hi_ok = 1'b0;
      chunk_left = '0;
      msg_bytes = '0;
      more_chunks = 1'b0;
      msg_open = 1'b0;
      tick_cnt = '0;
   endfunction

   // ack the chunk; report the message if no continuation is pending
   function automatic void close_chunk();
      add_result(KIND_TX, cmd_char, 8'h00, 16'h0000);
      add_result(KIND_TX, CHAR_ZERO, 8'h00, 16'h0000);
      add_result(KIND_TX, CHAR_ZERO, 8'h00, 16'h0000);
      in_payload = 1'b0;
      tick_cnt = '0;
      if (!more_chunks) begin
         add_result(KIND_DONE, 8'h00, cmd_char, msg_bytes);
         msg_bytes = '0;
         msg_open = 1'b0;
      end
   endfunction

   // returns the number of results the request adds to expected_results
   function automatic int model_request(input logic [1:0] rtype, input logic [7:0] b);
      int h;
      int unsigned len;
      int first;
      frame_result_type tmp;
      first = expected_results.size();
      if (stopped) return 0;
      case (rtype)
         REQ_BYTE: begin
            if (in_payload) begin
               add_result(KIND_PAYLOAD, b, 8'h00, 16'h0000);
               msg_bytes = msg_bytes + 16'd1;
               chunk_left = chunk_left - 8'd1;
               if (chunk_left == 0) close_chunk();
            end else if (hdr_pos == 2'd0) begin
               cmd_char = b;
               if (!msg_open) begin
                  msg_open = 1'b1;
                  tick_cnt = '0;
                  msg_bytes = '0;
               end
               hdr_pos = 2'd1;
            end else if (hdr_pos == 2'd1) begin
               h = nibble_value(b);
               hi_ok = (h >= 0);
               hi_nibble = (h >= 0) ? 8'(h) : 8'd0;
               hdr_pos = 2'd2;
            end else begin
               h = nibble_value(b);
               hdr_pos = 2'd0;
               tick_cnt = '0;
               if (cmd_char == CHAR_CR) begin
                  add_result(KIND_TX, CHAR_O, 8'h00, 16'h0000);
                  add_result(KIND_TX, CHAR_K, 8'h00, 16'h0000);
                  msg_open = more_chunks;
               end else begin
                  if (!hi_ok) len = 0;
                  else if (h < 0) len = hi_nibble;
                  else len = hi_nibble * 16 + h;
                  if (len > set_max_payload) begin
                     len = set_max_payload;
                     more_chunks = 1'b1;
                  end else begin
                     more_chunks = 1'b0;
                  end
                  if (len + msg_bytes > set_buffer_size) begin
                     add_result(KIND_OVERFLOW, 8'h00, 8'h00, 16'h0000);
                     drop_message();
                     stopped = 1'b1;
                  end else if (len == 0) begin
                     close_chunk();
                  end else begin
                     chunk_left = 8'(len);
                     in_payload = 1'b1;
                  end
               end
            end
         end
         REQ_TICK: begin
            if (msg_open && set_timeout_en) begin
               if (tick_cnt != 32'hFFFF_FFFF) tick_cnt = tick_cnt + 32'd1;
               if (tick_cnt > set_timeout) begin
                  dead_seen = 1'b1;
                  drop_message();
                  add_result(KIND_TIMEOUT, 8'h00, 8'h00, 16'h0000);
               end
            end
         end
         REQ_CLEAR: begin
            dead_seen = 1'b0;
            drop_message();
         end
         default: ;
      endcase
      for (int i = first; i < expected_results.size(); i++) begin
         tmp = expected_results[i];
         tmp.dead = dead_seen;
         tmp.last = (i == expected_results.size() - 1);
         expected_results[i] = tmp;
      end
      return expected_results.size() - first;
   endfunction

   task automatic check_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         mismatch_count++;
         $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, what, want, got);
      end
   endtask

   // ---------------- scoreboard and watchdog ----------------
   always @(posedge clock) begin : scoreboard
      frame_result_type want, got;
      int n, pos;
      logic moved;
      if (!reset) begin
         moved = 1'b0;
         if (csr_wr_en) begin
            moved = 1'b1;
            case (csr_index)
               CSR_MAX_PAYLOAD:    set_max_payload = csr_wdata[7:0];
               CSR_BUFFER_SIZE:    set_buffer_size = csr_wdata[15:0];
               CSR_TIMEOUT_TICKS:  set_timeout = csr_wdata;
               CSR_TIMEOUT_ENABLE: set_timeout_en = csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            got = '{rsp_out_kind, rsp_out_byte, rsp_msg_cmd, rsp_msg_total,
                    rsp_last_of_run, rsp_dead_flag};
            result_count++;
            if (got.kind <= KIND_TIMEOUT) kind_seen[got.kind]++;
            if (expected_results.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected result: expected none, got kind %0d byte 0x%0h",
                        $time, got.kind, got.data);
            end else begin
               want = expected_results.pop_front();
               check_field("out_kind", 32'(want.kind), 32'(got.kind));
               check_field("out_byte", 32'(want.data), 32'(got.data));
               check_field("msg_cmd", 32'(want.cmd), 32'(got.cmd));
               check_field("msg_total", 32'(want.total), 32'(got.total));
               check_field("last_of_run", 32'(want.last), 32'(got.last));
               check_field("dead_flag", 32'(want.dead), 32'(got.dead));
            end
         end
         if (req_valid && !req_stall) begin
            moved = 1'b1;
            n = model_request(req_req_type, req_rx_byte);
            if (req_count < DIR_ROWS && n > 0 && DIRECTED[req_count].chk) begin
               pos = expected_results.size() - n;
               want = expected_results[pos];
               want.kind = DIRECTED[req_count].ekind;
               want.data = DIRECTED[req_count].ebyte;
               expected_results[pos] = want;
            end
            req_count++;
         end
         if (moved) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog: no handshake for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, expected_results.size());
            $display("** chunked_frame_receiver_core: FAILED **");
            $finish;
         end
      end
   end

   // ---------------- response side pacing ----------------
   initial begin : rsp_pacing
      int run_len, hold_len, pick;
      forever begin
         if (hold_off_req) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            hold_off_req = 1'b0;
         end else begin
            rsp_stall <= 1'b0;
            run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 12);
            repeat (run_len) @(posedge clock);
            pick = $urandom_range(0, 9);
            if (pick < 6) hold_len = $urandom_range(1, 3);
            else if (pick < 9) hold_len = 0;
            else hold_len = $urandom_range(10, 50);
            if (hold_len > 0) begin
               rsp_stall <= 1'b1;
               repeat (hold_len) @(posedge clock);
            end
         end
      end
   end

   // ---------------- request side ----------------
   function automatic int pick_gap();
      int r;
      if (sender_burst > 0) begin
         sender_burst--;
         return 0;
      end
      if ($urandom_range(0, 30) == 0) sender_burst = $urandom_range(20, 60);
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // called at a clock edge; returns at the edge that accepts the request
   task automatic send_req(input logic [1:0] rtype, input logic [7:0] b);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_req_type <= rtype;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain_requests();
      link_req_type r;
      while (stim_q.size() != 0) begin
         r = stim_q.pop_front();
         send_req(r.rtype, r.rbyte);
      end
      req_valid <= 1'b0;
   endtask

   task automatic settle_idle();
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_settings(input logic [7:0] mp, input logic [15:0] bs,
                                 input logic [31:0] tt, input logic te);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_MAX_PAYLOAD;
      csr_wdata <= 32'(mp);
      @(posedge clock);
      csr_index <= CSR_BUFFER_SIZE;
      csr_wdata <= 32'(bs);
      @(posedge clock);
      csr_index <= CSR_TIMEOUT_TICKS;
      csr_wdata <= tt;
      @(posedge clock);
      csr_index <= CSR_TIMEOUT_ENABLE;
      csr_wdata <= 32'(te);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic push_req(input logic [1:0] rtype, input logic [7:0] b);
      stim_q.push_back('{rtype, b});
      if ($urandom_range(0, 9) == 0) stim_q.push_back('{REQ_TICK, 8'($urandom)});
   endtask

   function automatic logic [7:0] hex_char(input int v);
      if (v < 10) return 8'(8'h30 + v);
      if ($urandom_range(0, 1) == 1) return 8'(8'h61 + v - 10);
      return 8'(8'h41 + v - 10);
   endfunction

   function automatic logic [7:0] pick_cmd();
      logic [7:0] c;
      c = 8'($urandom);
      if (c == CHAR_CR) c = "R";
      return c;
   endfunction

   task automatic push_len(input int len);
      if (len == 0 && $urandom_range(0, 3) == 0) begin
         push_req(REQ_BYTE, NON_HEX[$urandom_range(0, 7)]);
         push_req(REQ_BYTE, 8'($urandom));
      end else if (len < 16 && $urandom_range(0, 3) == 0) begin
         push_req(REQ_BYTE, hex_char(len));
         push_req(REQ_BYTE, NON_HEX[$urandom_range(0, 7)]);
      end else begin
         push_req(REQ_BYTE, hex_char(len / 16));
         push_req(REQ_BYTE, hex_char(len % 16));
      end
   endtask

   task automatic gen_message(input int mp);
      int chunks, len, k;
      if (mp > 16 && $urandom_range(0, 4) == 0) begin
         // clamped chunk, cut short by a flush
         push_req(REQ_BYTE, pick_cmd());
         push_len(255);
         repeat (3) push_req(REQ_BYTE, 8'($urandom));
         push_req(REQ_CLEAR, 8'($urandom));
         return;
      end
      chunks = (mp <= 16) ? $urandom_range(1, 3) : 1;
      for (k = 0; k < chunks; k++) begin
         if (k < chunks - 1) len = $urandom_range(mp + 1, 255);
         else if (mp <= 16 && $urandom_range(0, 7) == 0) len = mp;
         else len = $urandom_range(0, (mp < 6) ? mp : 6);
         push_req(REQ_BYTE, pick_cmd());
         push_len(len);
         repeat ((len > mp) ? mp : len) push_req(REQ_BYTE, 8'($urandom));
      end
   endtask

   task automatic gen_noise();
      logic [7:0] junk;
      junk = 8'($urandom);
      case ($urandom_range(0, 5))
         0: begin
            push_req(REQ_BYTE, junk);
            if ($urandom_range(0, 1) == 1) push_req(REQ_CLEAR, 8'($urandom));
         end
         1: push_req(REQ_CLEAR, junk);
         2: push_req(REQ_SPARE, junk);
         3: begin
            push_req(REQ_BYTE, CHAR_CR);
            push_req(REQ_BYTE, junk);
            push_req(REQ_BYTE, 8'($urandom));
         end
         4: begin
            push_req(REQ_BYTE, pick_cmd());
            push_req(REQ_BYTE, hex_char($urandom_range(0, 15)));
            push_req(REQ_CLEAR, junk);
         end
         default: repeat ($urandom_range(1, 8)) push_req(REQ_TICK, 8'($urandom));
      endcase
   endtask

   task automatic run_phase(input logic [7:0] mp, input logic [15:0] bs,
                            input logic [31:0] tt, input logic te, input bit hold);
      settle_idle();
      write_settings(mp, bs, tt, te);
      while (stim_q.size() < PHASE_ITEMS) begin
         if ($urandom_range(0, 4) == 0) gen_noise();
         else gen_message(mp);
      end
      if (hold) hold_off_req = 1'b1;
      drain_requests();
   endtask

   initial begin : stimulus
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < DIR_ROWS; i++) send_req(DIRECTED[i].rtype, DIRECTED[i].rbyte);
      req_valid <= 1'b0;

      run_phase(8'd254, 16'd65535, 32'd3, 1'b1, 1'b1);
      run_phase(8'd0, 16'd65535, 32'd0, 1'b1, 1'b0);
      run_phase(8'd5, 16'd1000, 32'hFFFF_FFFF, 1'b1, 1'b0);
      run_phase(8'd16, 16'd4096, 32'($urandom), 1'b0, 1'b0);
      run_phase(8'd3, 16'd500, 32'd6, 1'b1, 1'b0);

      // zero-size buffer: empty message passes, first non-empty chunk overflows and halts
      settle_idle();
      write_settings(8'd8, 16'd0, 32'd100, 1'b1);
      stim_q.push_back('{REQ_BYTE, "M"});
      stim_q.push_back('{REQ_BYTE, "0"});
      stim_q.push_back('{REQ_BYTE, "0"});
      stim_q.push_back('{REQ_BYTE, "N"});
      stim_q.push_back('{REQ_BYTE, "0"});
      stim_q.push_back('{REQ_BYTE, "1"});
      stim_q.push_back('{REQ_BYTE, "P"});
      stim_q.push_back('{REQ_TICK, 8'h00});
      stim_q.push_back('{REQ_CLEAR, 8'hFF});
      stim_q.push_back('{REQ_SPARE, 8'h00});
      stim_q.push_back('{REQ_BYTE, "7"});
      drain_requests();
      settle_idle();
      repeat (20) @(posedge clock);

      $display("Covered %0d requests over 7 register settings; %0d results checked.",
               req_count, result_count);
      $display("Results: %0d payload, %0d transmit, %0d done, %0d overflow, %0d timeout.",
               kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4]);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("** chunked_frame_receiver_core: PASSED **");
      end else begin
         $display("%0d mismatches, %0d results never arrived",
                  mismatch_count, expected_results.size());
         $display("** chunked_frame_receiver_core: FAILED **");
      end
      $finish;
   end

endmodule
